[hw/rtl/lcs_pkg.sv]
// Shared types and constants for the longest-common-subsequence length block.
// No dependencies; used by lcs_cell and lcs_length.
`default_nettype none

package lcs_pkg;

  localparam int LCS_MAX_LEN     = 64;
  localparam int LCS_SYMBOL_BITS = 8;
  localparam int LCS_CMD_W       = 2;
  localparam int LCS_SYM_IN_W    = 8;
  localparam int LCS_LEN_W       = 7;

  localparam logic [LCS_CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [LCS_CMD_W-1:0] CMD_SECOND = 2'd1;
  localparam logic [LCS_CMD_W-1:0] CMD_FINISH = 2'd2;

  // Row-wide control broadcast to every cell.
  typedef struct packed {
    logic load;   // append: the first free cell takes the symbol
    logic clear;  // finish: empty the whole row
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/lcs_length.sv]
// LCS length: a second-string symbol is taken every cycle while not busy and
// ripples down the cell row one cell per cycle, passing all MAX_LEN cells in turn.
// Append and finish requests wait until the row has drained of those symbols;
// with the row idle they take effect at once.
// A finish strobes out_valid for one cycle in the cycle after it takes effect.
// Synchronous active-low reset empties the row and clears tail value and overflow.
// Depends on lcs_pkg and lcs_cell.
`default_nettype none

module lcs_length #(
  parameter int MAX_LEN     = lcs_pkg::LCS_MAX_LEN,
  parameter int SYMBOL_BITS = lcs_pkg::LCS_SYMBOL_BITS
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire  [lcs_pkg::LCS_CMD_W-1:0]      in_command,
  input  wire  [lcs_pkg::LCS_SYM_IN_W-1:0]   in_symbol,
  output logic                               out_valid,
  output logic [lcs_pkg::LCS_LEN_W-1:0]      out_lcs_length,
  output logic                               out_truncated
);
  import lcs_pkg::*;

  localparam int VAL_W = $clog2(MAX_LEN + 1);
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic                      accept;
  logic                      pending_r, pending_nxt;
  logic [LCS_CMD_W-1:0]      pend_cmd_r;
  logic [LCS_SYM_IN_W-1:0]   pend_sym_r;
  logic [LCS_CMD_W-1:0]      cmd_sel;
  logic [LCS_SYM_IN_W-1:0]   sym_sel;
  logic [SYMBOL_BITS+LCS_SYM_IN_W-1:0] sym_ext;
  logic [SYMBOL_BITS-1:0]    sym_cmp;
  logic                      req_op;
  logic                      exec;
  logic                      do_append;
  logic                      do_finish;
  logic                      inject;
  logic                      full;
  logic [CNT_W-1:0]          drain_cnt_r, drain_cnt_nxt;
  logic [VAL_W-1:0]          last_val_r, last_val_nxt;
  logic                      overflow_r, overflow_nxt;
  logic                      out_valid_r;
  logic [LCS_LEN_W-1:0]      out_len_r;
  logic                      out_trunc_r;
  logic [LCS_LEN_W+VAL_W-1:0] len_ext;
  cell_ctrl_t                ctrl;

  logic [MAX_LEN:0]          link_valid;
  logic [SYMBOL_BITS-1:0]    link_sym  [MAX_LEN+1];
  logic [VAL_W-1:0]          link_up   [MAX_LEN+1];
  logic [VAL_W-1:0]          link_diag [MAX_LEN+1];
  logic [MAX_LEN:0]          act_chain;

  assign busy    = pending_r;
  assign accept  = start && !busy;

  assign cmd_sel = pending_r ? pend_cmd_r : in_command;
  assign sym_sel = pending_r ? pend_sym_r : in_symbol;
  assign sym_ext = {{SYMBOL_BITS{1'b0}}, sym_sel};
  assign sym_cmp = sym_ext[SYMBOL_BITS-1:0];

  // Append and finish must see a drained row; hold them until then.
  assign req_op    = pending_r ||
                     (accept && (in_command == CMD_APPEND || in_command == CMD_FINISH));
  assign exec      = req_op && (drain_cnt_r == '0);
  assign do_append = exec && (cmd_sel == CMD_APPEND);
  assign do_finish = exec && (cmd_sel == CMD_FINISH);
  assign inject    = accept && (in_command == CMD_SECOND);
  assign full      = act_chain[MAX_LEN];

  assign pending_nxt = req_op && !exec;

  assign ctrl.load  = do_append && !full;
  assign ctrl.clear = do_finish;

  always_comb begin
    drain_cnt_nxt = drain_cnt_r;
    if (inject) begin
      drain_cnt_nxt = CNT_W'(MAX_LEN);
    end else if (drain_cnt_r != '0) begin
      drain_cnt_nxt = drain_cnt_r - CNT_W'(1);
    end
  end

  // Tail of the row carries the last occupied entry after each symbol.
  always_comb begin
    last_val_nxt = last_val_r;
    overflow_nxt = overflow_r;
    if (do_finish) begin
      last_val_nxt = '0;
      overflow_nxt = 1'b0;
    end else begin
      if (link_valid[MAX_LEN]) begin
        last_val_nxt = link_up[MAX_LEN];
      end
      if (do_append && full) begin
        overflow_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      drain_cnt_r <= '0;
      last_val_r  <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      last_val_r  <= last_val_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= do_finish;
    end
  end

  assign len_ext = {{LCS_LEN_W{1'b0}}, last_val_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_cmd_r <= in_command;
      pend_sym_r <= in_symbol;
    end
    if (do_finish) begin
      out_len_r   <= len_ext[LCS_LEN_W-1:0];
      out_trunc_r <= overflow_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_lcs_length = out_len_r;
  assign out_truncated  = out_trunc_r;

  // Head of the row: first row has zero above and zero on the diagonal.
  assign link_valid[0] = inject;
  assign link_sym[0]   = sym_cmp;
  assign link_up[0]    = '0;
  assign link_diag[0]  = '0;
  assign act_chain[0]  = 1'b1;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    lcs_cell #(
      .SYM_W (SYMBOL_BITS),
      .VAL_W (VAL_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .load_sym    (sym_cmp),
      .load_val    (last_val_r),
      .prev_active (act_chain[i]),
      .in_valid    (link_valid[i]),
      .in_sym      (link_sym[i]),
      .in_up       (link_up[i]),
      .in_diag     (link_diag[i]),
      .out_valid   (link_valid[i+1]),
      .out_sym     (link_sym[i+1]),
      .out_up      (link_up[i+1]),
      .out_diag    (link_diag[i+1]),
      .active      (act_chain[i+1])
    );
  end

  // A symbol leaves the row strictly before the drain count runs out.
  a_drain_cover: assert property (@(posedge clk) disable iff (!rst_n)
    link_valid[MAX_LEN] |-> drain_cnt_r != '0)
    else $error("lcs_length: symbol still in row after drain");

  // Append and finish never take effect with symbols in flight.
  a_exec_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (do_append || do_finish) |-> !(|link_valid))
    else $error("lcs_length: request executed on a busy row");

  // A finish leaves the row empty and the tail value cleared.
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !act_chain[1] && last_val_r == '0 && !overflow_r)
    else $error("lcs_length: state not cleared after finish");

  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    drain_cnt_r <= CNT_W'(MAX_LEN))
    else $error("lcs_length: drain count out of range");

endmodule

`default_nettype wire

[hw/rtl/lcs_cell.sv]
// One cell of the LCS row: holds one first-string symbol and its column entry.
// Depends on lcs_pkg (cell_ctrl_t).
`default_nettype none

module lcs_cell #(
  parameter int SYM_W = 8,
  parameter int VAL_W = 7
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire lcs_pkg::cell_ctrl_t ctrl,
  input  wire  [SYM_W-1:0]       load_sym,
  input  wire  [VAL_W-1:0]       load_val,
  input  wire                    prev_active,
  input  wire                    in_valid,
  input  wire  [SYM_W-1:0]       in_sym,
  input  wire  [VAL_W-1:0]       in_up,
  input  wire  [VAL_W-1:0]       in_diag,
  output logic                   out_valid,
  output logic [SYM_W-1:0]       out_sym,
  output logic [VAL_W-1:0]       out_up,
  output logic [VAL_W-1:0]       out_diag,
  output logic                   active
);
  import lcs_pkg::*;

  logic             active_r, active_nxt;
  logic [SYM_W-1:0] sym_r;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             out_valid_r;
  logic [SYM_W-1:0] out_sym_r;
  logic [VAL_W-1:0] out_up_r, out_up_nxt;
  logic [VAL_W-1:0] out_diag_r, out_diag_nxt;
  logic [VAL_W-1:0] diag_inc;
  logic [VAL_W-1:0] up_max;
  logic [VAL_W-1:0] best;
  logic             take_load;

  assign take_load = ctrl.load && prev_active && !active_r;
  assign diag_inc  = in_diag + VAL_W'(1);
  assign up_max    = (in_up > val_r) ? in_up : val_r;
  assign best      = (sym_r == in_sym && diag_inc > up_max) ? diag_inc : up_max;

  always_comb begin
    active_nxt = active_r;
    if (ctrl.clear) begin
      active_nxt = 1'b0;
    end else if (take_load) begin
      active_nxt = 1'b1;
    end
  end

  always_comb begin
    val_nxt      = val_r;
    out_up_nxt   = in_up;
    out_diag_nxt = in_diag;
    if (take_load) begin
      val_nxt = load_val;
    end else if (active_r) begin
      out_up_nxt   = best;
      out_diag_nxt = val_r;
      if (in_valid) begin
        val_nxt = best;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_load) begin
      sym_r <= load_sym;
    end
    val_r      <= val_nxt;
    out_sym_r  <= in_sym;
    out_up_r   <= out_up_nxt;
    out_diag_r <= out_diag_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_sym   = out_sym_r;
  assign out_up    = out_up_r;
  assign out_diag  = out_diag_r;
  assign active    = active_r;

  // Occupied cells form an unbroken run from the head of the row.
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> prev_active)
    else $error("lcs_cell: occupied cell behind a free one");

  // A column entry never shrinks while the cell stays occupied.
  a_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    active_r && $past(active_r) |-> val_r >= $past(val_r))
    else $error("lcs_cell: column entry decreased");

  // The value handed down is never below the diagonal handed with it.
  a_up_ge_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_up_r >= out_diag_r)
    else $error("lcs_cell: up below diagonal");

endmodule

`default_nettype wire

[bench/tb_lcs_length.sv]
`timescale 1ns / 100ps
// Self-checking bench for lcs_length: a directed stimulus table, then random string pairs.
// Checks each finish against a pin or the in-bench column recurrence. Depends on lcs_pkg.

module tb_lcs_length;
  import lcs_pkg::*;

  localparam logic [LCS_CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 2 * LCS_MAX_LEN + 16;
  localparam int N_ROWS = 23;
  localparam int N_PINNED = 16;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [LCS_LEN_W-1:0] length;
    logic                 truncated;
  } lcs_result_t;

  // One table row: a request repeated reps times; pinned rows carry a typed-in result.
  typedef struct packed {
    logic [LCS_CMD_W-1:0]    cmd;
    logic [LCS_SYM_IN_W-1:0] sym;
    logic [7:0]              reps;
    logic                    pinned;
    lcs_result_t             result;
  } stim_row_t;

  stim_row_t stim_rows [N_ROWS] = '{
    {CMD_FINISH, 8'h00, 8'd1,  1'b1, 7'd0,  1'b0},  // finish straight after reset
    {CMD_UNUSED, 8'hAA, 8'd1,  1'b0, 7'd0,  1'b0},
    {CMD_FINISH, 8'h00, 8'd1,  1'b1, 7'd0,  1'b0},
    {CMD_APPEND, 8'h00, 8'd1,  1'b0, 7'd0,  1'b0},
    {CMD_APPEND, 8'hFF, 8'd1,  1'b0, 7'd0,  1'b0},
    {CMD_SECOND, 8'hFF, 8'd1,  1'b0, 7'd0,  1'b0},
    {CMD_SECOND, 8'h00, 8'd1,  1'b0, 7'd0,  1'b0},
    {CMD_FINISH, 8'h00, 8'd1,  1'b0, 7'd0,  1'b0},
    {CMD_SECOND, 8'h55, 8'd3,  1'b0, 7'd0,  1'b0},  // empty first string
    {CMD_FINISH, 8'h00, 8'd1,  1'b1, 7'd0,  1'b0},
    {CMD_APPEND, 8'h41, 8'd64, 1'b0, 7'd0,  1'b0},  // full row, full match
    {CMD_SECOND, 8'h41, 8'd64, 1'b0, 7'd0,  1'b0},
    {CMD_FINISH, 8'hFF, 8'd1,  1'b1, 7'd64, 1'b0},
    {CMD_APPEND, 8'h7E, 8'd66, 1'b0, 7'd0,  1'b0},  // overflow drops two symbols
    {CMD_SECOND, 8'h7E, 8'd2,  1'b0, 7'd0,  1'b0},
    {CMD_FINISH, 8'h00, 8'd1,  1'b1, 7'd2,  1'b1},
    {CMD_SECOND, 8'h12, 8'd1,  1'b0, 7'd0,  1'b0},  // late appends pair only forwards
    {CMD_APPEND, 8'h12, 8'd1,  1'b0, 7'd0,  1'b0},
    {CMD_SECOND, 8'h34, 8'd1,  1'b0, 7'd0,  1'b0},
    {CMD_APPEND, 8'h34, 8'd1,  1'b0, 7'd0,  1'b0},
    {CMD_UNUSED, 8'h34, 8'd1,  1'b0, 7'd0,  1'b0},
    {CMD_SECOND, 8'h34, 8'd1,  1'b0, 7'd0,  1'b0},
    {CMD_FINISH, 8'h00, 8'd1,  1'b0, 7'd0,  1'b0}
  };

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [LCS_CMD_W-1:0]    in_command;
  logic [LCS_SYM_IN_W-1:0] in_symbol;
  logic                    out_valid;
  logic [LCS_LEN_W-1:0]    out_lcs_length;
  logic                    out_truncated;

  lcs_length dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_symbol      (in_symbol),
    .out_valid      (out_valid),
    .out_lcs_length (out_lcs_length),
    .out_truncated  (out_truncated)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Column model of the recurrence, updated on every accepted request
  logic [LCS_SYMBOL_BITS-1:0] row_symbol [LCS_MAX_LEN];
  logic [LCS_LEN_W-1:0]       column [LCS_MAX_LEN];
  int                         row_count;
  bit                         row_overflow;

  lcs_result_t pending_results [$];
  bit          pin_valid [N_PINNED];
  lcs_result_t pin_result [N_PINNED];
  int          finishes_sent;
  int          finishes_seen;
  int          failures;
  int          items_sent;
  int          burst_left;

  function automatic void lcs_clear();
    for (int i = 0; i < LCS_MAX_LEN; i++) begin
      row_symbol[i] = '0;
      column[i] = '0;
    end
    row_count = 0;
    row_overflow = 1'b0;
  endfunction

  function automatic bit lcs_apply(input logic [LCS_CMD_W-1:0] cmd,
                                   input logic [LCS_SYM_IN_W-1:0] sym,
                                   output lcs_result_t res);
    logic [LCS_SYMBOL_BITS-1:0] key;
    int diag, up, left, best;
    key = sym[LCS_SYMBOL_BITS-1:0];
    res = '0;
    if (cmd == CMD_APPEND) begin
      if (row_count >= LCS_MAX_LEN) begin
        row_overflow = 1'b1;
      end else begin
        row_symbol[row_count] = key;
        // a new row inherits the value above it
        column[row_count] = (row_count > 0) ? column[row_count - 1] : '0;
        row_count++;
      end
      return 1'b0;
    end
    if (cmd == CMD_SECOND) begin
      diag = 0;
      up = 0;
      for (int i = 0; i < row_count; i++) begin
        left = int'(column[i]);
        best = (up > left) ? up : left;
        if (row_symbol[i] == key && diag + 1 > best) best = diag + 1;
        column[i] = best[LCS_LEN_W-1:0];
        diag = left;
        up = best;
      end
      return 1'b0;
    end
    if (cmd == CMD_FINISH) begin
      res.length = (row_count > 0) ? column[row_count - 1] : '0;
      res.truncated = row_overflow;
      lcs_clear();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  // Check results first, then record the request taken at this edge
  always @(posedge clk) begin
    lcs_result_t got, want, fresh;
    if (rst_n && out_valid === 1'b1) begin
      got.length = out_lcs_length;
      got.truncated = out_truncated;
      if (pending_results.size() == 0) begin
        report_failure($sformatf("result with none pending: length %0d truncated %0b",
                                 got.length, got.truncated));
      end else begin
        want = pending_results.pop_front();
        if (got.length !== want.length)
          report_failure($sformatf("length: expected %0d, got %0d", want.length, got.length));
        if (got.truncated !== want.truncated)
          report_failure($sformatf("truncated: expected %0b, got %0b",
                                   want.truncated, got.truncated));
      end
    end
    if (rst_n && start === 1'b1 && busy === 1'b0) begin
      if (lcs_apply(in_command, in_symbol, fresh)) begin
        if (finishes_seen < N_PINNED && pin_valid[finishes_seen])
          fresh = pin_result[finishes_seen];
        pending_results.push_back(fresh);
        finishes_seen++;
      end
    end
  end

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Close the current burst now and then with a random gap
  task automatic pace();
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 9));
    end
  endtask

  task automatic send(input logic [LCS_CMD_W-1:0] cmd, input logic [LCS_SYM_IN_W-1:0] sym);
    start <= 1'b1;
    in_command <= cmd;
    in_symbol <= sym;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (cmd != CMD_UNUSED) items_sent++;
    if (cmd == CMD_FINISH) finishes_sent++;
    pace();
  endtask

  // Drop start and hold until every pending result has arrived
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [LCS_SYM_IN_W-1:0] pick_symbol(input int alphabet);
    if ($urandom_range(0, 4) == 0) return LCS_SYM_IN_W'($urandom_range(0, 255));
    return LCS_SYM_IN_W'(8'h60 + $urandom_range(0, alphabet - 1));
  endfunction

  // Mostly a well-formed pair; sometimes interleaved, noisy or left unfinished
  task automatic random_pair();
    int  n_first, n_second, alphabet;
    bit  mixed, take_first;
    n_first = ($urandom_range(0, 99) < 8) ? $urandom_range(60, 70) : $urandom_range(0, 12);
    n_second = ($urandom_range(0, 99) < 8) ? $urandom_range(30, 64) : $urandom_range(0, 12);
    alphabet = $urandom_range(1, 6);
    mixed = ($urandom_range(0, 6) == 0);
    while (n_first + n_second > 0) begin
      if ($urandom_range(0, 39) == 0)
        send(CMD_UNUSED, LCS_SYM_IN_W'($urandom_range(0, 255)));
      take_first = (n_second == 0) ||
                   (n_first > 0 && (!mixed || $urandom_range(0, 1) == 1));
      if (take_first) begin
        send(CMD_APPEND, pick_symbol(alphabet));
        n_first--;
      end else begin
        send(CMD_SECOND, pick_symbol(alphabet));
        n_second--;
      end
    end
    if ($urandom_range(0, 19) != 0) send(CMD_FINISH, LCS_SYM_IN_W'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_APPEND;
    in_symbol = '0;
    failures = 0;
    items_sent = 0;
    finishes_sent = 0;
    finishes_seen = 0;
    burst_left = $urandom_range(1, 40);
    lcs_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      if (stim_rows[r].cmd == CMD_FINISH && stim_rows[r].pinned && finishes_sent < N_PINNED) begin
        pin_valid[finishes_sent] = 1'b1;
        pin_result[finishes_sent] = stim_rows[r].result;
      end
      for (int k = 0; k < int'(stim_rows[r].reps); k++)
        send(stim_rows[r].cmd, stim_rows[r].sym);
    end
    settle();

    while (items_sent < RANDOM_ITEMS) begin
      random_pair();
      if ($urandom_range(0, 19) == 0) settle();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0)
      $display("[lcs_length] OK");
    else
      $display("[lcs_length] ERROR");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[lcs_length] ERROR");
    $finish;
  end

endmodule

[files.f]
hw/rtl/lcs_pkg.sv
hw/rtl/lcs_cell.sv
hw/rtl/lcs_length.sv
bench/tb_lcs_length.sv
